>>> rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// Point-triangle distance package
// Shared widths, types and region codes for the point-triangle distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Input and output geometry.
  localparam int COORD_W   = 32;
  localparam int NUM_COORD = 12;
  localparam int IN_W      = COORD_W * NUM_COORD;
  localparam int DIST_W    = 32;
  localparam int RGN_W     = 3;

  // Front-end arithmetic widths.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int NRM_W  = PROD_W + 1;
  localparam int WIDE_W = 2 * DOT_W + 1;
  localparam int T_W    = 102;

  // Wide multiplier: operands split into limbs.
  localparam int LIMB_W    = 26;
  localparam int MUL_LIMBS = 4;
  localparam int MUL_W     = LIMB_W * MUL_LIMBS;
  localparam int RES_W     = 2 * MUL_W;
  localparam int MUL_LAT   = 5;

  // Division and square root.
  localparam int NUM_W  = 204;
  localparam int DEN_W  = WIDE_W + 2;
  localparam int REM_W  = NUM_W + 1;
  localparam int QUO_W  = 2 * DIST_W;
  localparam int ROOT_W = DIST_W;
  localparam int SQ_W   = QUO_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [DOT_W:0]     dot_diff_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [T_W-1:0]     t_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [RES_W-1:0]   mul_res_t;
  typedef logic signed [DEN_W-1:0]   fden_t;
  typedef logic [NUM_W-1:0]          num_t;
  typedef logic [DEN_W-1:0]          den_t;

  typedef enum logic [RGN_W-1:0] {
    RGN_A    = 3'd0,
    RGN_B    = 3'd1,
    RGN_AB   = 3'd2,
    RGN_C    = 3'd3,
    RGN_AC   = 3'd4,
    RGN_BC   = 3'd5,
    RGN_FACE = 3'd6
  } region_t;

  // Dot products and wide products carried past the first multiplier bank.
  typedef struct packed {
    dot_t  d1, d2, d3, d4, d5, d6;
    dot_t  aa, bb, cc;
    dot_t  lab, lac, lbc;
    wide_t va, vb, vc;
    wide_t nab, nac, nbc;
  } geo_t;

  // Divider to square root hand-off.
  typedef struct packed {
    logic             valid;
    logic             sat;
    region_t          region;
    logic [QUO_W-1:0] q;
  } quo_t;

  // Final result.
  typedef struct packed {
    logic              valid;
    logic              sat;
    region_t           region;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/ptd_mul.sv
// ----------------------------------------------------------------------------
// Pipelined wide signed multiplier
// Sign-magnitude multiplier built from limb partial products over five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_mul (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire ptd_pkg::mul_op_t  a,
  input  wire ptd_pkg::mul_op_t  b,
  output ptd_pkg::mul_res_t      p
);
  import ptd_pkg::*;

  logic [MUL_W-1:0]    ma_r, mb_r;
  logic [2*LIMB_W-1:0] pp_r [MUL_LIMBS][MUL_LIMBS];
  logic [RES_W-1:0]    row_r [MUL_LIMBS];
  logic [RES_W-1:0]    row_nxt [MUL_LIMBS];
  logic [RES_W-1:0]    sum_r, sum_nxt;
  logic [3:0]          neg_r;
  mul_res_t            p_r;

  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < MUL_LIMBS; j++) begin
        row_nxt[i] = row_nxt[i] + (RES_W'(pp_r[i][j]) << (j * LIMB_W));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < MUL_LIMBS; i++) begin
      sum_nxt = sum_nxt + (row_r[i] << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= a[MUL_W-1] ? $unsigned(-a) : $unsigned(a);
      mb_r  <= b[MUL_W-1] ? $unsigned(-b) : $unsigned(b);
      neg_r <= {neg_r[2:0], a[MUL_W-1] ^ b[MUL_W-1]};
      for (int i = 0; i < MUL_LIMBS; i++) begin
        for (int j = 0; j < MUL_LIMBS; j++) begin
          pp_r[i][j] <= (2*LIMB_W)'(ma_r[i*LIMB_W +: LIMB_W]) *
                        (2*LIMB_W)'(mb_r[j*LIMB_W +: LIMB_W]);
        end
      end
      row_r <= row_nxt;
      sum_r <= sum_nxt;
      p_r   <= neg_r[3] ? -$signed(sum_r) : $signed(sum_r);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

>>> rtl/core/ptd_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Saturation check, then one quotient bit per stage for a 64-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire ptd_pkg::num_t     num,
  input  wire ptd_pkg::den_t     den,
  input  wire ptd_pkg::region_t  region,
  output ptd_pkg::quo_t          quo
);
  import ptd_pkg::*;

  localparam int STEPS = QUO_W;

  logic             v_r   [STEPS+1];
  logic             sat_r [STEPS+1];
  region_t          rgn_r [STEPS+1];
  logic [REM_W-1:0] rem_r [STEPS+1];
  den_t             dn_r  [STEPS+1];
  logic [QUO_W-1:0] q_r   [STEPS+1];

  // Quotient reaches 2^64 or more exactly when num >= den * 2^64.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= {1'b0, num} >= (REM_W'(den) << STEPS);
      rem_r[0] <= REM_W'(num);
      dn_r[0]  <= den;
      rgn_r[0] <= region;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;
    logic [REM_W-1:0] trial;
    logic             fit;

    assign trial = REM_W'(dn_r[k]) << SH;
    assign fit   = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= fit ? rem_r[k] - trial : rem_r[k];
        q_r[k+1]   <= {q_r[k][QUO_W-2:0], fit};
        dn_r[k+1]  <= dn_r[k];
        sat_r[k+1] <= sat_r[k];
        rgn_r[k+1] <= rgn_r[k];
      end
    end
  end

  assign quo.valid  = v_r[STEPS];
  assign quo.sat    = sat_r[STEPS];
  assign quo.region = rgn_r[STEPS];
  assign quo.q      = q_r[STEPS];

  // A finished unsaturated division leaves a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STEPS] && !sat_r[STEPS] |-> rem_r[STEPS] < REM_W'(dn_r[STEPS]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/core/ptd_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one root bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_sqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire ptd_pkg::quo_t  quo,
  output ptd_pkg::res_t       res
);
  import ptd_pkg::*;

  logic              v_r   [ROOT_W];
  logic              sat_r [ROOT_W];
  region_t           rgn_r [ROOT_W];
  logic [SQ_W-1:0]   y_r   [ROOT_W];
  logic [ROOT_W-1:0] r_r   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int B = ROOT_W - 1 - k;
    logic              v_in, sat_in;
    region_t           rgn_in;
    logic [SQ_W-1:0]   y_in, trial;
    logic [ROOT_W-1:0] r_in;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in   = quo.valid;
      assign sat_in = quo.sat;
      assign rgn_in = quo.region;
      assign y_in   = SQ_W'(quo.q);
      assign r_in   = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign sat_in = sat_r[k-1];
      assign rgn_in = rgn_r[k-1];
      assign y_in   = y_r[k-1];
      assign r_in   = r_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (SQ_W'(r_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
    assign fit   = y_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_r[k]   <= fit ? y_in - trial : y_in;
        r_r[k]   <= fit ? (r_in | (ROOT_W'(1) << B)) : r_in;
        sat_r[k] <= sat_in;
        rgn_r[k] <= rgn_in;
      end
    end
  end

  assign res.valid    = v_r[ROOT_W-1];
  assign res.sat      = sat_r[ROOT_W-1];
  assign res.region   = rgn_r[ROOT_W-1];
  assign res.distance = sat_r[ROOT_W-1] ? '1 : r_r[ROOT_W-1];

  // A floor root leaves x - r^2 no larger than 2r.
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ROOT_W-1] && !sat_r[ROOT_W-1] |->
      y_r[ROOT_W-1] <= (SQ_W'(r_r[ROOT_W-1]) << 1))
    else $error("square root remainder out of range");

endmodule

`default_nettype wire

>>> rtl/core/point_triangle_distance.sv
// ----------------------------------------------------------------------------
// Point-triangle distance
// Distance from a query point to a 3D triangle, with its closest-point region.
// ----------------------------------------------------------------------------
// The input stream carries one triangle and one query point per transaction,
// twelve signed Q16.16 coordinates packed into in_tdata. The output stream
// returns the truncated Euclidean distance in unsigned Q16.16 on out_tdata and
// the Voronoi region plus a saturation flag on out_tuser. Region tests use
// exact integer dot products; the squared distance is an exact ratio that a
// 64-stage restoring divider turns into an integer, and a 32-stage digit
// square root gives the distance.
//
// The path from input transaction to output transaction runs through three
// front-end stages, two five-stage wide multiplier banks with one stage
// between them, one region select stage, the divider with its saturation
// stage, and the square root. The divider and root, one bit per stage, set
// that depth. Throughput is one transaction per cycle while the output is not stalled.
//
// Reset clears every valid bit, so the output is empty after reset. When the
// receiver holds out_tready low with a result waiting, the whole pipeline
// freezes and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module point_triangle_distance (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_y, query_z
  input  wire logic [ptd_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // distance
  output logic [ptd_pkg::DIST_W-1:0]     out_tdata,
  // region[2:0], saturated[3]
  output logic [ptd_pkg::RGN_W:0]        out_tuser
);
  import ptd_pkg::*;

  // Dot product slots.
  localparam int DT_D1  = 0;
  localparam int DT_D2  = 1;
  localparam int DT_D3  = 2;
  localparam int DT_D4  = 3;
  localparam int DT_D5  = 4;
  localparam int DT_D6  = 5;
  localparam int DT_AA  = 6;
  localparam int DT_BB  = 7;
  localparam int DT_CC  = 8;
  localparam int DT_LAB = 9;
  localparam int DT_LAC = 10;
  localparam int DT_LBC = 11;
  localparam int DT_E   = 12;
  localparam int DT_N   = 13;

  // First multiplier bank slots.
  localparam int M_D1D4  = 0;
  localparam int M_D3D2  = 1;
  localparam int M_D5D2  = 2;
  localparam int M_D1D6  = 3;
  localparam int M_D3D6  = 4;
  localparam int M_D5D4  = 5;
  localparam int M_AALAB = 6;
  localparam int M_D1SQ  = 7;
  localparam int M_AALAC = 8;
  localparam int M_D2SQ  = 9;
  localparam int M_BBLBC = 10;
  localparam int M_ESQ   = 11;
  localparam int M_T0    = 12;
  localparam int M_T1    = 13;
  localparam int M_T2    = 14;
  localparam int M_N     = 15;

  // The whole pipeline advances together unless a result waits at the output with out_tready low.
  logic adv;
  res_t res;

  assign adv       = !res.valid || out_tready;
  assign in_tready = adv;

  // Stage 1: edge and offset vectors.
  coord_t pa [3], pb [3], pc [3], pq [3];
  diff_t  ab_r [3], ac_r [3], ap_r [3], bp_r [3], cp_r [3], bc_r [3];
  logic   v1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = coord_t'(in_tdata[k*COORD_W +: COORD_W]);
      pb[k] = coord_t'(in_tdata[(3+k)*COORD_W +: COORD_W]);
      pc[k] = coord_t'(in_tdata[(6+k)*COORD_W +: COORD_W]);
      pq[k] = coord_t'(in_tdata[(9+k)*COORD_W +: COORD_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab_r[k] <= diff_t'(pb[k]) - diff_t'(pa[k]);
        ac_r[k] <= diff_t'(pc[k]) - diff_t'(pa[k]);
        ap_r[k] <= diff_t'(pq[k]) - diff_t'(pa[k]);
        bp_r[k] <= diff_t'(pq[k]) - diff_t'(pb[k]);
        cp_r[k] <= diff_t'(pq[k]) - diff_t'(pc[k]);
        bc_r[k] <= diff_t'(pc[k]) - diff_t'(pb[k]);
      end
    end
  end

  // Stage 2: per-axis products for every dot product and the normal.
  prod_t pr_r [DT_N][3];
  prod_t cx_r [6];
  diff_t ap2_r [3];
  logic  v2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pr_r[DT_D1][k]  <= ab_r[k] * ap_r[k];
        pr_r[DT_D2][k]  <= ac_r[k] * ap_r[k];
        pr_r[DT_D3][k]  <= ab_r[k] * bp_r[k];
        pr_r[DT_D4][k]  <= ac_r[k] * bp_r[k];
        pr_r[DT_D5][k]  <= ab_r[k] * cp_r[k];
        pr_r[DT_D6][k]  <= ac_r[k] * cp_r[k];
        pr_r[DT_AA][k]  <= ap_r[k] * ap_r[k];
        pr_r[DT_BB][k]  <= bp_r[k] * bp_r[k];
        pr_r[DT_CC][k]  <= cp_r[k] * cp_r[k];
        pr_r[DT_LAB][k] <= ab_r[k] * ab_r[k];
        pr_r[DT_LAC][k] <= ac_r[k] * ac_r[k];
        pr_r[DT_LBC][k] <= bc_r[k] * bc_r[k];
        pr_r[DT_E][k]   <= bc_r[k] * bp_r[k];
      end
      cx_r[0] <= ab_r[1] * ac_r[2];
      cx_r[1] <= ab_r[2] * ac_r[1];
      cx_r[2] <= ab_r[2] * ac_r[0];
      cx_r[3] <= ab_r[0] * ac_r[2];
      cx_r[4] <= ab_r[0] * ac_r[1];
      cx_r[5] <= ab_r[1] * ac_r[0];
      ap2_r   <= ap_r;
    end
  end

  // Stage 3: dot product sums and the triangle normal.
  dot_t  dt_r [DT_N];
  nrm_t  nrm_r [3];
  diff_t ap3_r [3];
  logic  v3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DT_N; i++) begin
        dt_r[i] <= dot_t'(pr_r[i][0]) + dot_t'(pr_r[i][1]) + dot_t'(pr_r[i][2]);
      end
      nrm_r[0] <= nrm_t'(cx_r[0]) - nrm_t'(cx_r[1]);
      nrm_r[1] <= nrm_t'(cx_r[2]) - nrm_t'(cx_r[3]);
      nrm_r[2] <= nrm_t'(cx_r[4]) - nrm_t'(cx_r[5]);
      ap3_r    <= ap2_r;
    end
  end

  // First multiplier bank: barycentric terms, edge numerators, normal dot.
  mul_op_t  ma [M_N], mb [M_N];
  mul_res_t mp [M_N];

  always_comb begin
    ma[M_D1D4]  = mul_op_t'(dt_r[DT_D1]);  mb[M_D1D4]  = mul_op_t'(dt_r[DT_D4]);
    ma[M_D3D2]  = mul_op_t'(dt_r[DT_D3]);  mb[M_D3D2]  = mul_op_t'(dt_r[DT_D2]);
    ma[M_D5D2]  = mul_op_t'(dt_r[DT_D5]);  mb[M_D5D2]  = mul_op_t'(dt_r[DT_D2]);
    ma[M_D1D6]  = mul_op_t'(dt_r[DT_D1]);  mb[M_D1D6]  = mul_op_t'(dt_r[DT_D6]);
    ma[M_D3D6]  = mul_op_t'(dt_r[DT_D3]);  mb[M_D3D6]  = mul_op_t'(dt_r[DT_D6]);
    ma[M_D5D4]  = mul_op_t'(dt_r[DT_D5]);  mb[M_D5D4]  = mul_op_t'(dt_r[DT_D4]);
    ma[M_AALAB] = mul_op_t'(dt_r[DT_AA]);  mb[M_AALAB] = mul_op_t'(dt_r[DT_LAB]);
    ma[M_D1SQ]  = mul_op_t'(dt_r[DT_D1]);  mb[M_D1SQ]  = mul_op_t'(dt_r[DT_D1]);
    ma[M_AALAC] = mul_op_t'(dt_r[DT_AA]);  mb[M_AALAC] = mul_op_t'(dt_r[DT_LAC]);
    ma[M_D2SQ]  = mul_op_t'(dt_r[DT_D2]);  mb[M_D2SQ]  = mul_op_t'(dt_r[DT_D2]);
    ma[M_BBLBC] = mul_op_t'(dt_r[DT_BB]);  mb[M_BBLBC] = mul_op_t'(dt_r[DT_LBC]);
    ma[M_ESQ]   = mul_op_t'(dt_r[DT_E]);   mb[M_ESQ]   = mul_op_t'(dt_r[DT_E]);
    ma[M_T0]    = mul_op_t'(nrm_r[0]);     mb[M_T0]    = mul_op_t'(ap3_r[0]);
    ma[M_T1]    = mul_op_t'(nrm_r[1]);     mb[M_T1]    = mul_op_t'(ap3_r[1]);
    ma[M_T2]    = mul_op_t'(nrm_r[2]);     mb[M_T2]    = mul_op_t'(ap3_r[2]);
  end

  for (genvar m = 0; m < M_N; m++) begin : g_mul1
    ptd_mul u_mul (
      .clk (clk),
      .en  (adv),
      .a   (ma[m]),
      .b   (mb[m]),
      .p   (mp[m])
    );
  end

  dot_t dl1_r [MUL_LAT][DT_N];
  logic vm1_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_r[0] <= dt_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dl1_r[i] <= dl1_r[i-1];
      end
    end
  end

  // Stage 4: region determinants, edge numerators and the plane offset.
  geo_t s4_r;
  t_t   t_r;
  logic v4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r.d1  <= dl1_r[MUL_LAT-1][DT_D1];
      s4_r.d2  <= dl1_r[MUL_LAT-1][DT_D2];
      s4_r.d3  <= dl1_r[MUL_LAT-1][DT_D3];
      s4_r.d4  <= dl1_r[MUL_LAT-1][DT_D4];
      s4_r.d5  <= dl1_r[MUL_LAT-1][DT_D5];
      s4_r.d6  <= dl1_r[MUL_LAT-1][DT_D6];
      s4_r.aa  <= dl1_r[MUL_LAT-1][DT_AA];
      s4_r.bb  <= dl1_r[MUL_LAT-1][DT_BB];
      s4_r.cc  <= dl1_r[MUL_LAT-1][DT_CC];
      s4_r.lab <= dl1_r[MUL_LAT-1][DT_LAB];
      s4_r.lac <= dl1_r[MUL_LAT-1][DT_LAC];
      s4_r.lbc <= dl1_r[MUL_LAT-1][DT_LBC];
      s4_r.vc  <= wide_t'(mp[M_D1D4]) - wide_t'(mp[M_D3D2]);
      s4_r.vb  <= wide_t'(mp[M_D5D2]) - wide_t'(mp[M_D1D6]);
      s4_r.va  <= wide_t'(mp[M_D3D6]) - wide_t'(mp[M_D5D4]);
      s4_r.nab <= wide_t'(mp[M_AALAB]) - wide_t'(mp[M_D1SQ]);
      s4_r.nac <= wide_t'(mp[M_AALAC]) - wide_t'(mp[M_D2SQ]);
      s4_r.nbc <= wide_t'(mp[M_BBLBC]) - wide_t'(mp[M_ESQ]);
      t_r      <= t_t'(mp[M_T0]) + t_t'(mp[M_T1]) + t_t'(mp[M_T2]);
    end
  end

  // Second multiplier bank: square of the plane offset for the face case.
  mul_res_t tt;
  geo_t     dl2_r [MUL_LAT];
  logic     vm2_r [MUL_LAT];

  ptd_mul u_mul_face (
    .clk (clk),
    .en  (adv),
    .a   (mul_op_t'(t_r)),
    .b   (mul_op_t'(t_r)),
    .p   (tt)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_r[0] <= s4_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dl2_r[i] <= dl2_r[i-1];
      end
    end
  end

  // Stage 5: region select in priority order, then numerator and denominator.
  geo_t      g;
  dot_diff_t d43, d56;
  fden_t     fden;
  num_t      num_nxt, num_r;
  den_t      den_nxt, den_r;
  region_t   rgn_nxt, rgn_r;
  logic      v5_r;

  always_comb begin
    g       = dl2_r[MUL_LAT-1];
    d43     = dot_diff_t'(g.d4) - dot_diff_t'(g.d3);
    d56     = dot_diff_t'(g.d5) - dot_diff_t'(g.d6);
    fden    = fden_t'(g.va) + fden_t'(g.vb) + fden_t'(g.vc);
    num_nxt = num_t'(g.aa);
    den_nxt = den_t'(1);
    rgn_nxt = RGN_A;
    priority if (g.d1 <= 0 && g.d2 <= 0) begin
      rgn_nxt = RGN_A;
    end else if (g.d3 >= 0 && d43 <= 0) begin
      num_nxt = num_t'(g.bb);
      rgn_nxt = RGN_B;
    end else if (g.vc <= 0 && g.d1 >= 0 && g.d3 <= 0) begin
      rgn_nxt = RGN_AB;
      // A zero-length edge measures to its start vertex.
      if (g.lab > 0) begin
        num_nxt = num_t'(g.nab);
        den_nxt = den_t'(g.lab);
      end
    end else if (g.d6 >= 0 && d56 <= 0) begin
      num_nxt = num_t'(g.cc);
      rgn_nxt = RGN_C;
    end else if (g.vb <= 0 && g.d2 >= 0 && g.d6 <= 0) begin
      rgn_nxt = RGN_AC;
      if (g.lac > 0) begin
        num_nxt = num_t'(g.nac);
        den_nxt = den_t'(g.lac);
      end
    end else if (g.va <= 0 && d43 >= 0 && d56 >= 0) begin
      rgn_nxt = RGN_BC;
      num_nxt = num_t'(g.bb);
      if (g.lbc > 0) begin
        num_nxt = num_t'(g.nbc);
        den_nxt = den_t'(g.lbc);
      end
    end else if (fden > 0) begin
      num_nxt = num_t'(tt);
      den_nxt = den_t'(fden);
      rgn_nxt = RGN_FACE;
    end else begin
      // A degenerate face falls back to vertex A.
      rgn_nxt = RGN_A;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      rgn_r <= rgn_nxt;
    end
  end

  // Valid bits travel alongside the data through the front end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      vm1_r <= '{default: 1'b0};
      vm2_r <= '{default: 1'b0};
    end else if (adv) begin
      v1_r     <= in_tvalid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      vm1_r[0] <= v3_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        vm1_r[i] <= vm1_r[i-1];
        vm2_r[i] <= vm2_r[i-1];
      end
      v4_r     <= vm1_r[MUL_LAT-1];
      vm2_r[0] <= v4_r;
      v5_r     <= vm2_r[MUL_LAT-1];
    end
  end

  // Division to an integer squared distance, then the square root.
  quo_t quo;

  ptd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v5_r),
    .num      (num_r),
    .den      (den_r),
    .region   (rgn_r),
    .quo      (quo)
  );

  ptd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .quo   (quo),
    .res   (res)
  );

  assign out_tvalid = res.valid;
  assign out_tdata  = res.distance;
  assign out_tuser  = {res.sat, res.region};

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stall freezes the front end.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v5_r) && $stable(rgn_r))
    else $error("front end moved during a stall");

  // A waiting result holds its value until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

endmodule

`default_nettype wire
